### rtl/tent_filter_kernel_generator_core_defines.svh
// Assertion macros for the port-level checker of the tent kernel generator.
`ifndef TENT_FILTER_KERNEL_GENERATOR_CORE_DEFINES_SVH
`define TENT_FILTER_KERNEL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TFK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tent kernel check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define TFK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tent kernel check failed: next-cycle rule");

`endif

### rtl/tfk_pkg.sv
// Package with the types, constants and helper functions of the tent kernel generator.
package tfk_pkg;

   // Largest kernel side in taps.
   localparam logic [3:0] MAX_TAPS = 4'd8;

   // Dividend width of p * 65535 and the number of restoring division steps.
   localparam int DIV_WIDTH = 20;
   localparam int STEP_WIDTH = $clog2(DIV_WIDTH);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic calc_sum;
      logic load_div;
      logic div_step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;
      logic out_free;
      logic tap_last;
   } status_type;

   // Saturate a requested size into the range one to MAX_TAPS.
   function automatic logic [3:0] clamp_size(input logic [3:0] size);
      logic [3:0] result;
      begin
         if (size == 4'd0) begin
            result = 4'd1;
         end else if (size > MAX_TAPS) begin
            result = MAX_TAPS;
         end else begin
            result = size;
         end
         return result;
      end
   endfunction

   // Sum of the tent factors over a side of n taps.
   function automatic logic [4:0] tent_sum(input logic [3:0] n);
      logic [4:0] result;
      begin
         unique case (n)
            4'd1:    result = 5'd1;
            4'd2:    result = 5'd2;
            4'd3:    result = 5'd4;
            4'd4:    result = 5'd6;
            4'd5:    result = 5'd9;
            4'd6:    result = 5'd12;
            4'd7:    result = 5'd16;
            4'd8:    result = 5'd20;
            default: result = 5'd0;
         endcase
         return result;
      end
   endfunction

   // Tent factor of tap i on a side of n taps: min(i + 1, n - i).
   function automatic logic [3:0] tent_factor(input logic [2:0] i, input logic [3:0] n);
      logic [3:0] up;
      logic [3:0] down;
      begin
         up = {1'b0, i} + 4'd1;
         down = n - {1'b0, i};
         return (up < down) ? up : down;
      end
   endfunction

endpackage

### rtl/tfk_ctrl.sv
// Controller state machine that sequences setup, division and output of each kernel tap.
module tfk_ctrl
   import tfk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.calc_sum = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.tap_last ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/tfk_datapath.sv
// Datapath: latched sizes, tap counters, weight sum, serial divider and output register.
module tfk_datapath
   import tfk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [3:0]  req_x_size,
   input  logic [3:0]  req_y_size,
   output status_type  sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_weight,
   output logic [2:0]  rsp_col,
   output logic [2:0]  rsp_row,
   output logic        rsp_last
);

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(DIV_WIDTH - 1);

   logic [3:0]            width_ff,  width_in;
   logic [3:0]            height_ff, height_in;
   logic [2:0]            col_ff,    col_in;
   logic [2:0]            row_ff,    row_in;
   logic [8:0]            sum_ff,    sum_in;
   logic [8:0]            rem_ff,    rem_in;
   logic [DIV_WIDTH-1:0]  dq_ff,     dq_in;
   logic [STEP_WIDTH-1:0] step_ff,   step_in;
   logic                  valid_ff,  valid_in;
   logic [15:0]           weight_ff, weight_in;
   logic [2:0]            ocol_ff,   ocol_in;
   logic [2:0]            orow_ff,   orow_in;
   logic                  olast_ff,  olast_in;

   logic [9:0]  sum_product;
   logic [7:0]  raw_product;
   logic [4:0]  raw_weight;
   logic [20:0] scaled;
   logic [9:0]  trial;
   logic [9:0]  diff;
   logic        fits;
   logic        col_end;
   logic        row_end;
   logic        out_free;

   // Raw tap weight and its scaling by 65535 as a shift and subtract.
   assign raw_product = tent_factor(col_ff, width_ff) * tent_factor(row_ff, height_ff);
   assign raw_weight = raw_product[4:0];
   assign scaled = {raw_weight, 16'h0000} - {16'h0000, raw_weight};
   assign sum_product = tent_sum(width_ff) * tent_sum(height_ff);

   // One restoring division step.
   assign trial = {rem_ff, dq_ff[DIV_WIDTH-1]};
   assign diff = trial - {1'b0, sum_ff};
   assign fits = trial >= {1'b0, sum_ff};

   // Position of the current tap in the kernel.
   assign col_end = ({1'b0, col_ff} == (width_ff - 4'd1));
   assign row_end = ({1'b0, row_ff} == (height_ff - 4'd1));
   assign out_free = !valid_ff || !rsp_stall;

   assign sts.div_last = (step_ff == LAST_STEP);
   assign sts.out_free = out_free;
   assign sts.tap_last = col_end && row_end;

   // Size latch, tap counters and weight sum.
   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      if (cmd.latch) begin
         width_in = clamp_size(req_x_size);
         height_in = clamp_size(req_y_size);
         col_in = 3'd0;
         row_in = 3'd0;
      end
      if (cmd.calc_sum) begin
         sum_in = sum_product[8:0];
      end
      if (cmd.emit) begin
         if (col_end) begin
            col_in = 3'd0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_ff + 3'd1;
         end
      end
   end

   // Serial divider: remainder, shifting dividend and quotient, step count.
   always_comb begin
      rem_in = rem_ff;
      dq_in = dq_ff;
      step_in = step_ff;
      if (cmd.load_div) begin
         rem_in = 9'd0;
         dq_in = scaled[DIV_WIDTH-1:0];
         step_in = '0;
      end else if (cmd.div_step) begin
         rem_in = fits ? diff[8:0] : trial[8:0];
         dq_in = {dq_ff[DIV_WIDTH-2:0], fits};
         step_in = step_ff + STEP_WIDTH'(1);
      end
   end

   // Output register: loaded on emit, held while the receiver stalls.
   always_comb begin
      weight_in = weight_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      olast_in = olast_ff;
      valid_in = valid_ff && rsp_stall;
      if (cmd.emit) begin
         valid_in = 1'b1;
         weight_in = dq_ff[15:0];
         ocol_in = col_ff;
         orow_in = row_ff;
         olast_in = col_end && row_end;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff <= '0;
         width_ff <= 4'd0;
         height_ff <= 4'd0;
         col_ff <= 3'd0;
         row_ff <= 3'd0;
         sum_ff <= 9'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff <= step_in;
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff <= dq_in;
      weight_ff <= weight_in;
      ocol_ff <= ocol_in;
      orow_ff <= orow_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_weight = weight_ff;
   assign rsp_col = ocol_ff;
   assign rsp_row = orow_ff;
   assign rsp_last = olast_ff;

endmodule

### rtl/tent_filter_kernel_generator_core.sv
// Top level of the tent (Bartlett) supersampling kernel generator.
//
// A request transfer on the req_ channel carries the kernel width and height
// in taps; zero counts as one tap and sizes above eight saturate to eight.
// The block answers with width * height result transfers on the rsp_ channel
// in row-major order, each holding floor(p * 65535 / sum) for the raw tent
// product p of the tap, its column and row, and a last flag on the final tap.
// Each weight comes from a 20-step restoring divider, one quotient bit per
// cycle. Each tap takes a divider load, 20 divide steps and an emit, and a
// request adds a size latch and a weight sum setup ahead of its first tap.
// req_stall is low only while the block is idle; a new request can be taken
// while the final weight of the previous kernel still waits in the output
// register. While the receiver stalls, the output register holds its weight
// and the divider finishes the next one, then waits for the register to free.
// Synchronous reset clears the controller, the output valid and the sizes.
module tent_filter_kernel_generator_core
   import tfk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_x_size,
   input  logic [3:0]  req_y_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_weight,
   output logic [2:0]  rsp_col,
   output logic [2:0]  rsp_row,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type sts;

   // Sequencer.
   tfk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and output register.
   tfk_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_x_size (req_x_size),
      .req_y_size (req_y_size),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_weight (rsp_weight),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_last   (rsp_last)
   );

endmodule

### rtl/tfk_checker.sv
// Port-level checker for the tent kernel generator, bound to the top level.
`include "tent_filter_kernel_generator_core_defines.svh"

module tfk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_weight,
   input logic [2:0]  rsp_col,
   input logic [2:0]  rsp_row,
   input logic        rsp_last
);

   logic req_xfer;
   logic rsp_held;
   logic single_tap;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign single_tap = rsp_valid && rsp_last && rsp_col == 3'd0 && rsp_row == 3'd0;

   // A stalled result keeps its valid and payload.
   `TFK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held,
      rsp_valid && $stable(rsp_weight) && $stable(rsp_col) && $stable(rsp_row) && $stable(rsp_last))

   // The block is busy in the cycle after it takes a request.
   `TFK_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall)

   // Every raw product is at least 1 and the sum at most 400, so no weight is zero.
   `TFK_ASSERT_NOW(a_weight_nonzero, clock, reset, rsp_valid, rsp_weight != 16'd0)

   // A single-tap kernel carries the full-scale weight.
   `TFK_ASSERT_NOW(a_single_tap_full, clock, reset, single_tap, rsp_weight == 16'hFFFF)

endmodule

bind tent_filter_kernel_generator_core tfk_checker u_tfk_checker (.*);

### sim/tb_tent_filter_kernel_generator_core.sv
// Self-checking testbench for the tent filter kernel generator core.
`timescale 1ns / 100ps

module tb_tent_filter_kernel_generator_core
   import tfk_pkg::*;
();

   // No transfer for this many cycles means the block has hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed after the final weight for any stray transfer to show up.
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_REQUESTS = 400;

   // One expected weight of a kernel.
   typedef struct packed {
      logic [15:0] weight;
      logic [2:0]  col;
      logic [2:0]  row;
      logic        last;
   } tap_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_x_size = 4'd0;
   logic [3:0]  req_y_size = 4'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_weight;
   logic [2:0]  rsp_col;
   logic [2:0]  rsp_row;
   logic        rsp_last;

   tap_result_type kernel_weight_q[$];
   tap_result_type want_tap;
   tap_result_type got_tap;
   int          error_count = 0;
   int          requests_sent = 0;
   int          weights_checked = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   bit          idling_on = 1'b1;

   tent_filter_kernel_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_x_size (req_x_size),
      .req_y_size (req_y_size),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_weight (rsp_weight),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_last   (rsp_last)
   );

   // Free-running 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requested side length saturated into one to eight taps.
   function automatic int unsigned side_taps(input logic [3:0] size);
      if (size == 4'd0) begin
         return 1;
      end
      if (size > MAX_TAPS) begin
         return MAX_TAPS;
      end
      return size;
   endfunction

   // Tent factor of tap i on a side of n taps.
   function automatic int unsigned tent_weight(input int unsigned i, input int unsigned n);
      return (i + 1 < n - i) ? i + 1 : n - i;
   endfunction

   // Queue the normalized kernel that a request of this size must produce.
   function automatic void predict_kernel(input logic [3:0] x_req, input logic [3:0] y_req);
      int unsigned width;
      int unsigned height;
      int unsigned col_total;
      int unsigned row_total;
      int unsigned product;
      tap_result_type tap;
      width = side_taps(x_req);
      height = side_taps(y_req);
      col_total = 0;
      row_total = 0;
      for (int unsigned x = 0; x < width; x++) begin
         col_total += tent_weight(x, width);
      end
      for (int unsigned y = 0; y < height; y++) begin
         row_total += tent_weight(y, height);
      end
      for (int unsigned y = 0; y < height; y++) begin
         for (int unsigned x = 0; x < width; x++) begin
            product = tent_weight(x, width) * tent_weight(y, height);
            tap.weight = 16'((product * 65535) / (col_total * row_total));
            tap.col = 3'(x);
            tap.row = 3'(y);
            tap.last = (x + 1 == width) && (y + 1 == height);
            kernel_weight_q.push_back(tap);
         end
      end
   endfunction

   // Report one field that differs from its expected value.
   function automatic void check_field(input string field, input int unsigned want,
                                       input logic [15:0] got);
      if (got !== 16'(want)) begin
         $display("%0t: %s differs: expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Receiver: holds off a random number of cycles after each result transfer.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = idling_on ? $urandom_range(0, 4) : 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   // Monitor: check each result transfer, then predict on each request transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_tap = {rsp_weight, rsp_col, rsp_row, rsp_last};
            if (kernel_weight_q.size() == 0) begin
               $display("%0t: unexpected weight %0d at col %0d row %0d", $time,
                        rsp_weight, rsp_col, rsp_row);
               error_count++;
            end else begin
               want_tap = kernel_weight_q.pop_front();
               check_field("weight", want_tap.weight, got_tap.weight);
               check_field("col", want_tap.col, 16'(got_tap.col));
               check_field("row", want_tap.row, 16'(got_tap.row));
               check_field("last", want_tap.last, 16'(got_tap.last));
               weights_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_kernel(req_x_size, req_y_size);
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tent_filter_kernel_generator_core: mismatch");
      $finish;
   end

   // Send one request after a random gap; valid stays high after the transfer.
   task automatic send_request(input logic [3:0] x_req, input logic [3:0] y_req);
      int unsigned gap;
      gap = idling_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_size <= x_req;
      req_y_size <= y_req;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // Sizes of zero and one: a single weight of full scale.
   task automatic test_single_tap();
      send_request(4'd0, 4'd0);
      send_request(4'd1, 4'd1);
      send_request(4'd0, 4'd1);
      send_request(4'd1, 4'd0);
   endtask

   // Sizes above eight saturate to eight.
   task automatic test_saturation();
      send_request(4'd15, 4'd15);
      send_request(4'd9, 4'd3);
      send_request(4'd3, 4'd12);
      send_request(4'd8, 4'd15);
      send_request(4'd0, 4'd8);
      send_request(4'd10, 4'd0);
   endtask

   // Square and oblong kernels over odd and even sides, up to the largest.
   task automatic test_kernel_shapes();
      for (int n = 2; n <= 8; n++) begin
         send_request(4'(n), 4'(n));
      end
      send_request(4'd1, 4'd8);
      send_request(4'd8, 4'd1);
      send_request(4'd2, 4'd7);
      send_request(4'd6, 4'd3);
   endtask

   // Random sizes, mostly in range, with stretches of both busy and idle traffic.
   task automatic test_random_kernels();
      logic [3:0] x_req;
      logic [3:0] y_req;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 50 == 0) begin
            idling_on = (i == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 3) == 0) begin
            x_req = 4'($urandom_range(0, 15));
            y_req = 4'($urandom_range(0, 15));
         end else begin
            x_req = 4'($urandom_range(1, 8));
            y_req = 4'($urandom_range(1, 8));
         end
         send_request(x_req, y_req);
      end
      idling_on = 1'b1;
   endtask

   // Test sequence.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_single_tap();
      test_saturation();
      test_kernel_shapes();
      test_random_kernels();
      req_valid <= 1'b0;
      // Let the monitor queue the last kernel before waiting for the queue to drain.
      @(posedge clock);
      while (kernel_weight_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d kernel requests (single tap, saturated, every side 1 to 8, random).",
               requests_sent);
      $display("Checked %0d weights under random request gaps and receiver stalls.",
               weights_checked);
      if (error_count == 0) begin
         $display("tent_filter_kernel_generator_core: match");
      end else begin
         $display("tent_filter_kernel_generator_core: mismatch");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/tfk_pkg.sv
rtl/tfk_ctrl.sv
rtl/tfk_datapath.sv
rtl/tent_filter_kernel_generator_core.sv
rtl/tfk_checker.sv
sim/tb_tent_filter_kernel_generator_core.sv
